// ===== sv/olist_pkg.sv =====
// Shared types and constants for the ordered list engine.
`timescale 1ns / 1ps

package olist_pkg;

   // Default list depth
   localparam int CAPACITY_DEF = 16;

   // Field widths of the request and response channels
   localparam int DATA_W   = 32;
   localparam int REQ_W    = 3;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 3;
   localparam int FOUND_W  = 4;
   localparam int COUNT_W  = 5;

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT      = 3'd0,
      REQ_APPEND      = 3'd1,
      REQ_REMOVE      = 3'd2,
      REQ_REMOVE_LAST = 3'd3,
      REQ_SEARCH      = 3'd4,
      REQ_COUNT       = 3'd5
   } req_code_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUT,
      S_SEARCH_RD,
      S_SEARCH_CMP
   } state_type;

endpackage

// ===== sv/olist_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module olist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ordered_list_engine.sv =====
// Count requests, tail removals and rejected requests answer in the cycle after acceptance.
// Insert: each shifted entry takes a RAM read and a RAM write, then the new value is stored;
// remove: a RAM read and a RAM write per shifted entry; search: a read and a compare per entry.
// One request at a time: busy stays high until the response strobe; the receiver
// cannot stall, so every response is a single-cycle strobe.
// Synchronous reset empties the list at once; RAM contents are not cleared.
`timescale 1ns / 1ps

module ordered_list_engine #(
   parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [olist_pkg::REQ_W-1:0]           req_type,
   input  logic signed [olist_pkg::DATA_W-1:0]   req_key_value,
   input  logic [olist_pkg::POS_W-1:0]           req_position,
   output logic                                  rsp_strobe,
   output logic [olist_pkg::STATUS_W-1:0]        rsp_status,
   output logic [olist_pkg::FOUND_W-1:0]         rsp_found_position,
   output logic [olist_pkg::COUNT_W-1:0]         rsp_entry_count
);

   import olist_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [AW-1:0] A_ONE = AW'(1);
   localparam logic [WW-1:0] W_ONE = WW'(1);
   localparam logic [WW-1:0] W_CAP = WW'(CAPACITY);

   // Control and datapath registers
   state_type               state_ff, state_in;
   req_code_type            op_ff, op_in;
   logic [AW-1:0]           cursor_ff, cursor_in;
   logic [AW-1:0]           tgt_ff, tgt_in;
   logic [DATA_W-1:0]       key_ff, key_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [FOUND_W-1:0]      rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // RAM ports
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [DATA_W-1:0]       wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [DATA_W-1:0]       rd_data;

   // Widened views for comparisons
   logic [WW-1:0]           cnt_w, pos_w, last_w, p_w, cnt_next_w, found_w;
   logic [AW-1:0]           cursor_step;
   req_code_type            req_code;

   olist_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_olist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cnt_w    = WW'(count_ff);
   assign pos_w    = WW'(req_position);
   assign last_w   = cnt_w - W_ONE;
   assign found_w  = WW'(cursor_ff);
   assign req_code = req_code_type'(req_type);

   // Shift moves toward the target: down for insert, up for remove
   assign cursor_step = (op_ff == REQ_INSERT) ? (cursor_ff - A_ONE) : (cursor_ff + A_ONE);

   // Next state, RAM control and response
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cursor_in     = cursor_ff;
      tgt_in        = tgt_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_found_in  = '0;
      wr_en         = 1'b0;
      wr_addr       = cursor_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = cursor_ff;
      p_w           = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_code)
                  REQ_INSERT, REQ_APPEND: begin
                     if (req_code == REQ_APPEND || cnt_w == '0) begin
                        p_w = (req_code == REQ_APPEND) ? cnt_w : '0;
                     end else begin
                        p_w = pos_w;
                     end
                     if (cnt_w == W_CAP) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else if (p_w > cnt_w) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        op_in     = REQ_INSERT;
                        key_in    = req_key_value;
                        tgt_in    = AW'(p_w);
                        cursor_in = AW'(cnt_w);
                        state_in  = (p_w == cnt_w) ? S_PUT : S_SHIFT_RD;
                     end
                  end
                  REQ_REMOVE, REQ_REMOVE_LAST: begin
                     p_w = (req_code == REQ_REMOVE) ? pos_w : last_w;
                     if (cnt_w == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else if (p_w >= cnt_w) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else if (p_w == last_w) begin
                        // Removing the tail needs no shifting
                        count_in      = count_ff - CW'(1);
                        rsp_strobe_in = 1'b1;
                     end else begin
                        op_in     = REQ_REMOVE;
                        tgt_in    = AW'(last_w);
                        cursor_in = AW'(p_w);
                        state_in  = S_SHIFT_RD;
                     end
                  end
                  REQ_SEARCH: begin
                     if (cnt_w == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_NOTFOUND;
                     end else begin
                        key_in    = req_key_value;
                        tgt_in    = AW'(last_w);
                        cursor_in = '0;
                        state_in  = S_SEARCH_RD;
                     end
                  end
                  default: begin
                     // Count and unused codes report the count only
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         // Fetch the neighbor that moves into the cursor slot
         S_SHIFT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cursor_step;
            state_in = S_SHIFT_WR;
         end

         S_SHIFT_WR: begin
            wr_en     = 1'b1;
            wr_addr   = cursor_ff;
            wr_data   = rd_data;
            cursor_in = cursor_step;
            if (cursor_step == tgt_ff) begin
               if (op_ff == REQ_INSERT) begin
                  state_in = S_PUT;
               end else begin
                  count_in      = count_ff - CW'(1);
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_SHIFT_RD;
            end
         end

         // Store the new value at its slot
         S_PUT: begin
            wr_en         = 1'b1;
            wr_addr       = tgt_ff;
            wr_data       = key_ff;
            count_in      = count_ff + CW'(1);
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end

         S_SEARCH_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cursor_ff;
            state_in = S_SEARCH_CMP;
         end

         S_SEARCH_CMP: begin
            if (rd_data == key_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_found_in  = found_w[FOUND_W-1:0];
               state_in      = S_IDLE;
            end else if (cursor_ff == tgt_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_NOTFOUND;
               state_in      = S_IDLE;
            end else begin
               cursor_in = cursor_ff + A_ONE;
               state_in  = S_SEARCH_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cnt_next_w   = WW'(count_in);
   assign rsp_count_in = cnt_next_w[COUNT_W-1:0];

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cursor_ff <= cursor_in;
      tgt_ff    <= tgt_in;
      key_ff    <= key_in;
      if (rsp_strobe_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule

// ===== sv/olist_checker.sv =====
// Port-level checks for the ordered list engine, bound to the top level.
`timescale 1ns / 1ps

module olist_checker #(
   parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_strobe,
   input logic [olist_pkg::STATUS_W-1:0]        rsp_status,
   input logic [olist_pkg::FOUND_W-1:0]         rsp_found_position,
   input logic [olist_pkg::COUNT_W-1:0]         rsp_entry_count
);

   import olist_pkg::*;

   localparam logic [COUNT_W-1:0] CAP_MASKED = COUNT_W'(CAPACITY);

   // An accepted request either answers at once or holds busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("request neither answered nor in progress");

   // Only defined status codes come out
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == ST_OK || rsp_status == ST_EMPTY ||
                      rsp_status == ST_RANGE || rsp_status == ST_FULL ||
                      rsp_status == ST_NOTFOUND))
      else $error("undefined status code");

   // Failed requests carry no found position
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_found_position == '0))
      else $error("found position set on a failed request");

   // Full and empty flags agree with the reported count
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> (rsp_entry_count == CAP_MASKED))
      else $error("full status with a count below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_EMPTY) |-> (rsp_entry_count == '0))
      else $error("empty status with a nonzero count");

endmodule

bind ordered_list_engine olist_checker #(.CAPACITY(CAPACITY)) u_olist_checker (.*);
